@@ hdl/mwm_pkg.sv @@
`timescale 1ns / 1ps

package mwm_pkg;

  // Word length limit and derived widths
  localparam int MaxWordBits = 32;
  localparam int ShiftW      = MaxWordBits;
  localparam int BitsW       = $clog2(MaxWordBits + 1);
  localparam int BitIdxW     = $clog2(MaxWordBits);

  // Field widths
  localparam int FuncW    = 3;
  localparam int WordW    = 32;
  localparam int LenW     = 6;
  localparam int TmoW     = 24;
  localparam int HalfW    = 16;
  localparam int WaitW    = 20;
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 2;

  // Stream widths (payload rounded up to whole bytes)
  localparam int InDataW  = 64;
  localparam int OutDataW = 40;

  // Output tdata bit positions
  localparam int OutClkBit  = 0;
  localparam int OutDiBit   = 1;
  localparam int OutRstBit  = 2;
  localparam int OutBusyBit = 3;
  localparam int OutDoneBit = 4;
  localparam int OutRdLsb   = 5;
  localparam int OutTmoBit  = OutRdLsb + WordW;

  // Command codes
  localparam logic [FuncW-1:0] FuncTick  = 3'd0;
  localparam logic [FuncW-1:0] FuncSend  = 3'd1;
  localparam logic [FuncW-1:0] FuncRecv  = 3'd2;
  localparam logic [FuncW-1:0] FuncWait  = 3'd3;
  localparam logic [FuncW-1:0] FuncReset = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgResetLow    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgResetSettle = 2'd2;

  // Register reset values
  localparam logic [HalfW-1:0] HalfPeriodRst  = 16'd5;
  localparam logic [WaitW-1:0] ResetLowRst    = 20'd1000;
  localparam logic [WaitW-1:0] ResetSettleRst = 20'd50000;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_LOW  = 4'd1,
    PH_S_HIGH = 4'd2,
    PH_R_LOW  = 4'd3,
    PH_R_HIGH = 4'd4,
    PH_W_SEL  = 4'd5,
    PH_W_REL  = 4'd6,
    PH_W_POLL = 4'd7,
    PH_D_LOW  = 4'd8,
    PH_D_SET  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [WordW-1:0] data_word;
    logic [LenW-1:0]  word_length;
    logic [TmoW-1:0]  timeout_ticks;
    logic             do_pin;
  } in_item_t;

  typedef struct packed {
    logic             clk_pin;
    logic             di_pin;
    logic             reset_pin;
    logic             busy_res;
    logic             done_res;
    logic [WordW-1:0] read_data;
    logic             timed_out;
  } result_t;

endpackage

@@ hdl/mwm_seq.sv @@
`timescale 1ns / 1ps

// Command sequencer: one tick per step, result computed from the next state
module mwm_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mwm_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              step_i,
  input  mwm_pkg::in_item_t                 item_i,
  output mwm_pkg::result_t                  res_o
);

  mwm_pkg::phase_e                   phase_q, phase_d;
  logic [mwm_pkg::ShiftW-1:0]        shift_q, shift_d;
  logic [mwm_pkg::BitsW-1:0]         bits_q, bits_d;
  logic [mwm_pkg::WaitW-1:0]         wait_q, wait_d;
  logic [mwm_pkg::TmoW-1:0]          poll_q, poll_d;
  logic                              clk_lvl_q, clk_lvl_d;
  logic                              di_lvl_q, di_lvl_d;
  logic                              rst_lvl_q, rst_lvl_d;
  logic                              tmo_q, tmo_d;
  logic [mwm_pkg::WordW-1:0]         rd_q, rd_d;
  logic                              done;

  logic [mwm_pkg::HalfW-1:0]         half_q;
  logic [mwm_pkg::WaitW-1:0]         rlow_q;
  logic [mwm_pkg::WaitW-1:0]         rset_q;
  logic [mwm_pkg::WaitW-1:0]         half_ext;

  logic [mwm_pkg::BitsW-1:0]         len_sat;
  logic [mwm_pkg::BitsW-1:0]         bits_dec;
  logic [mwm_pkg::ShiftW-1:0]        shift_ld;
  logic [mwm_pkg::ShiftW-1:0]        shift_in;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= mwm_pkg::HalfPeriodRst;
      rlow_q <= mwm_pkg::ResetLowRst;
      rset_q <= mwm_pkg::ResetSettleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mwm_pkg::CfgHalfPeriod:  half_q <= cfg_data_i[mwm_pkg::HalfW-1:0];
        mwm_pkg::CfgResetLow:    rlow_q <= cfg_data_i;
        mwm_pkg::CfgResetSettle: rset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign half_ext = mwm_pkg::WaitW'(half_q);

  // Length saturation and helper values
  always_comb begin
    if (32'(item_i.word_length) > 32'(mwm_pkg::MaxWordBits)) begin
      len_sat = mwm_pkg::BitsW'(mwm_pkg::MaxWordBits);
    end else begin
      len_sat = mwm_pkg::BitsW'(item_i.word_length);
    end
    bits_dec = (bits_q != '0) ? bits_q - 1'b1 : bits_q;
    shift_ld = mwm_pkg::ShiftW'(item_i.data_word);
    shift_in = {shift_q[mwm_pkg::ShiftW-2:0], item_i.do_pin};
  end

  // Next state for one tick
  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    wait_d    = wait_q;
    poll_d    = poll_q;
    clk_lvl_d = clk_lvl_q;
    di_lvl_d  = di_lvl_q;
    rst_lvl_d = rst_lvl_q;
    tmo_d     = tmo_q;
    rd_d      = rd_q;
    done      = 1'b0;

    if (phase_q == mwm_pkg::PH_IDLE) begin
      if (item_i.func == mwm_pkg::FuncSend) begin
        clk_lvl_d = 1'b0;
        if (len_sat == '0) begin
          di_lvl_d = 1'b0;
          done     = 1'b1;
        end else begin
          shift_d  = shift_ld;
          bits_d   = len_sat;
          di_lvl_d = shift_ld[mwm_pkg::BitIdxW'(len_sat - 1'b1)];
          wait_d   = half_ext;
          phase_d  = mwm_pkg::PH_S_LOW;
        end
      end else if (item_i.func == mwm_pkg::FuncRecv) begin
        clk_lvl_d = 1'b0;
        shift_d   = '0;
        if (len_sat == '0) begin
          rd_d = '0;
          done = 1'b1;
        end else begin
          bits_d  = len_sat;
          wait_d  = half_ext;
          phase_d = mwm_pkg::PH_R_LOW;
        end
      end else if (item_i.func == mwm_pkg::FuncWait) begin
        clk_lvl_d = 1'b0;
        rst_lvl_d = 1'b0;
        poll_d    = item_i.timeout_ticks;
        wait_d    = half_ext;
        phase_d   = mwm_pkg::PH_W_SEL;
      end else if (item_i.func == mwm_pkg::FuncReset) begin
        clk_lvl_d = 1'b0;
        di_lvl_d  = 1'b1;
        rst_lvl_d = 1'b0;
        wait_d    = rlow_q;
        phase_d   = mwm_pkg::PH_D_LOW;
      end
    end else if (phase_q == mwm_pkg::PH_W_POLL) begin
      // poll DO until high or out of ticks
      if (poll_q == '0) begin
        tmo_d   = 1'b1;
        done    = 1'b1;
        phase_d = mwm_pkg::PH_IDLE;
      end else if (item_i.do_pin) begin
        tmo_d   = 1'b0;
        done    = 1'b1;
        phase_d = mwm_pkg::PH_IDLE;
      end else begin
        poll_d = poll_q - 1'b1;
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - 1'b1;
    end else begin
      case (phase_q)
        mwm_pkg::PH_S_LOW: begin
          clk_lvl_d = 1'b1;
          wait_d    = half_ext;
          phase_d   = mwm_pkg::PH_S_HIGH;
        end
        mwm_pkg::PH_R_LOW: begin
          clk_lvl_d = 1'b1;
          wait_d    = half_ext;
          phase_d   = mwm_pkg::PH_R_HIGH;
        end
        mwm_pkg::PH_S_HIGH: begin
          clk_lvl_d = 1'b0;
          bits_d    = bits_dec;
          if (bits_dec == '0) begin
            di_lvl_d = 1'b0;
            done     = 1'b1;
            phase_d  = mwm_pkg::PH_IDLE;
          end else begin
            di_lvl_d = shift_q[mwm_pkg::BitIdxW'(bits_dec - 1'b1)];
            wait_d   = half_ext;
            phase_d  = mwm_pkg::PH_S_LOW;
          end
        end
        mwm_pkg::PH_R_HIGH: begin
          shift_d   = shift_in;
          clk_lvl_d = 1'b0;
          bits_d    = bits_dec;
          if (bits_dec == '0) begin
            rd_d    = mwm_pkg::WordW'(shift_in);
            done    = 1'b1;
            phase_d = mwm_pkg::PH_IDLE;
          end else begin
            wait_d  = half_ext;
            phase_d = mwm_pkg::PH_R_LOW;
          end
        end
        mwm_pkg::PH_W_SEL: begin
          rst_lvl_d = 1'b1;
          wait_d    = half_ext;
          phase_d   = mwm_pkg::PH_W_REL;
        end
        mwm_pkg::PH_W_REL: begin
          clk_lvl_d = 1'b0;
          phase_d   = mwm_pkg::PH_W_POLL;
        end
        mwm_pkg::PH_D_LOW: begin
          rst_lvl_d = 1'b1;
          wait_d    = rset_q;
          phase_d   = mwm_pkg::PH_D_SET;
        end
        default: begin
          done    = 1'b1;
          phase_d = mwm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res_o.clk_pin   = clk_lvl_d;
    res_o.di_pin    = di_lvl_d;
    res_o.reset_pin = rst_lvl_d;
    res_o.busy_res  = (phase_d != mwm_pkg::PH_IDLE);
    res_o.done_res  = done;
    res_o.read_data = rd_d;
    res_o.timed_out = tmo_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mwm_pkg::PH_IDLE;
      shift_q   <= '0;
      bits_q    <= '0;
      wait_q    <= '0;
      poll_q    <= '0;
      clk_lvl_q <= 1'b0;
      di_lvl_q  <= 1'b0;
      rst_lvl_q <= 1'b1;
      tmo_q     <= 1'b0;
      rd_q      <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      wait_q    <= wait_d;
      poll_q    <= poll_d;
      clk_lvl_q <= clk_lvl_d;
      di_lvl_q  <= di_lvl_d;
      rst_lvl_q <= rst_lvl_d;
      tmo_q     <= tmo_d;
      rd_q      <= rd_d;
    end
  end

endmodule

@@ hdl/microwire_bus_master_core.sv @@
`timescale 1ns / 1ps

// Channel   | Dir | Signals              | Contents (low bit first)
// ----------+-----+----------------------+--------------------------------------------
// s_axis    | in  | tvalid tready tdata  | tdata: data_word, word_length, timeout_ticks,
//           |     | tuser                |        do_pin; tuser: func
// m_axis    | out | tvalid tready tdata  | clk_pin, di_pin, reset_pin, busy_res, done_res,
//           |     |                      | read_data, timed_out
// cfg       | in  | we idx data          | 0 half_period, 1 reset_low, 2 reset_settle
//
// One item per cycle sustained while m_axis is ready; each item gives one result, passing
// through the input register, then the sequencer step into the result register.
// Reset leaves the sequencer idle with clock and data pins low, select pin high.
// A stalled m_axis holds its result; one more item waits in the input register,
// after which s_axis_tready drops until the result is taken.
module microwire_bus_master_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_word[31:0], word_length[37:32], timeout_ticks[61:38], do_pin[62]
  input  logic [mwm_pkg::InDataW-1:0]       s_axis_tdata,
  // func[2:0]
  input  logic [mwm_pkg::FuncW-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // clk_pin[0], di_pin[1], reset_pin[2], busy_res[3], done_res[4],
  // read_data[36:5], timed_out[37]
  output logic [mwm_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [mwm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mwm_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic              in_vld_q;
  mwm_pkg::in_item_t in_q, in_d;
  logic              out_vld_q;
  mwm_pkg::result_t  out_q;
  mwm_pkg::result_t  res;
  logic              step;

  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  // Unpack incoming item
  always_comb begin
    in_d.func          = s_axis_tuser;
    in_d.data_word     = s_axis_tdata[31:0];
    in_d.word_length   = s_axis_tdata[37:32];
    in_d.timeout_ticks = s_axis_tdata[61:38];
    in_d.do_pin        = s_axis_tdata[62];
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  mwm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (in_q),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  // Pack result
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.timed_out, out_q.read_data, out_q.done_res,
                          out_q.busy_res, out_q.reset_pin, out_q.di_pin, out_q.clk_pin};

endmodule

@@ hdl/mwm_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the result stream
module mwm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mwm_pkg::OutDataW-1:0]  m_axis_tdata
);

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Completion always leaves the master idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[mwm_pkg::OutDoneBit] |-> !m_axis_tdata[mwm_pkg::OutBusyBit])
    else $error("done reported while busy");

  // Serial clock is only high inside a command
  a_clk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[mwm_pkg::OutClkBit] |-> m_axis_tdata[mwm_pkg::OutBusyBit])
    else $error("serial clock high while idle");

  // Select line is only driven low inside a command
  a_sel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[mwm_pkg::OutRstBit] |-> m_axis_tdata[mwm_pkg::OutBusyBit])
    else $error("select line low while idle");

endmodule

bind microwire_bus_master_core mwm_checker u_mwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
